FILE: src/imhq_pkg.sv
// shared types and constants for the indexed min-heap queue
// used by the heap memories, the top level and its checker; no dependencies
package imhq_pkg;

  localparam int NODE_COUNT_DEF = 4096;
  localparam int ID_W           = 12;
  localparam int KEY_W          = 32;
  localparam int REQ_W          = 2;
  localparam int STAT_W         = 3;
  localparam int CNT_W          = 13;

  typedef enum logic [REQ_W-1:0] {
    REQ_PUSH  = 2'd0,
    REQ_POP   = 2'd1,
    REQ_DEC   = 2'd2,
    REQ_CLEAR = 2'd3
  } req_e;

  typedef enum logic [STAT_W-1:0] {
    ST_OK      = 3'd0,
    ST_EMPTY   = 3'd1,
    ST_FULL    = 3'd2,
    ST_PRESENT = 3'd3,
    ST_ABSENT  = 3'd4
  } status_e;

  typedef enum logic [3:0] {
    S_INIT,
    S_IDLE,
    S_LOOKUP,
    S_VERIFY,
    S_UP_ISSUE,
    S_UP_CMP,
    S_POP_LD,
    S_DN_ISSUE,
    S_DN_CMP
  } state_e;

endpackage

FILE: src/imhq_heap_mem.sv
// heap slot memory: node id and key per slot, one write and two read ports
// read data registered; depends on imhq_pkg
module imhq_heap_mem #(
  parameter int NODE_COUNT = imhq_pkg::NODE_COUNT_DEF,
  localparam int AW = (NODE_COUNT > 1) ? $clog2(NODE_COUNT) : 1
) (
  input  logic                       clk_i,
  input  logic                       we_i,
  input  logic [AW-1:0]              waddr_i,
  input  logic [imhq_pkg::ID_W-1:0]  wid_i,
  input  logic [imhq_pkg::KEY_W-1:0] wkey_i,
  input  logic                       re_i,
  input  logic [AW-1:0]              raddr0_i,
  input  logic [AW-1:0]              raddr1_i,
  output logic [imhq_pkg::ID_W-1:0]  rid0_o,
  output logic [imhq_pkg::KEY_W-1:0] rkey0_o,
  output logic [imhq_pkg::ID_W-1:0]  rid1_o,
  output logic [imhq_pkg::KEY_W-1:0] rkey1_o
);

  logic [imhq_pkg::ID_W-1:0]  ids_mem  [NODE_COUNT];
  logic [imhq_pkg::KEY_W-1:0] keys_mem [NODE_COUNT];

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      ids_mem[waddr_i]  <= wid_i;
      keys_mem[waddr_i] <= wkey_i;
    end
  end

  // two registered read ports
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rid0_o  <= ids_mem[raddr0_i];
      rkey0_o <= keys_mem[raddr0_i];
      rid1_o  <= ids_mem[raddr1_i];
      rkey1_o <= keys_mem[raddr1_i];
    end
  end

endmodule

FILE: src/imhq_slot_mem.sv
// slot-of-node memory: heap slot plus one for each node id
// one write and one registered read port; depends on imhq_pkg
module imhq_slot_mem #(
  parameter int NODE_COUNT = imhq_pkg::NODE_COUNT_DEF,
  localparam int AW = (NODE_COUNT > 1) ? $clog2(NODE_COUNT) : 1,
  localparam int CW = $clog2(NODE_COUNT + 1)
) (
  input  logic          clk_i,
  input  logic          we_i,
  input  logic [AW-1:0] waddr_i,
  input  logic [CW-1:0] wdata_i,
  input  logic          re_i,
  input  logic [AW-1:0] raddr_i,
  output logic [CW-1:0] rdata_o
);

  logic [CW-1:0] slot_mem [NODE_COUNT];

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      slot_mem[waddr_i] <= wdata_i;
    end
  end

  // registered read port
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= slot_mem[raddr_i];
    end
  end

endmodule

FILE: src/indexed_min_heap_queue.sv
// indexed binary min-heap queue: sequencer over heap and slot-of-node memories
// depends on imhq_pkg, imhq_heap_mem, imhq_slot_mem
//
//  channel   | handshake          | payload
//  ----------+--------------------+---------------------------------------------
//  request   | start_i / busy_o   | req_type_i, node_id_i, new_key_i
//  result    | done_o (1 cycle)   | pop_valid_o, popped_node_o, popped_key_o,
//            |                    | status_o, entry_count_o
//
// a transaction is taken when start_i is high and busy_o low; busy_o stays high
// until its result strobe. clear and requests rejected on taking need no memory
// access; push and decrease-key read the slot entry, check the heap id where the
// entry is valid, then sift up one level per parent read; pop reads the root and
// last slot, then sifts down reading both children of a level on the heap
// memory's dual read port. after reset a clearing pass zeroes the slot-of-node
// memory while busy_o is high. the receiver cannot stall the result.
module indexed_min_heap_queue #(
  parameter int NODE_COUNT = imhq_pkg::NODE_COUNT_DEF
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  input  logic [imhq_pkg::REQ_W-1:0]  req_type_i,
  input  logic [imhq_pkg::ID_W-1:0]   node_id_i,
  input  logic [imhq_pkg::KEY_W-1:0]  new_key_i,
  output logic                        busy_o,
  output logic                        done_o,
  output logic                        pop_valid_o,
  output logic [imhq_pkg::ID_W-1:0]   popped_node_o,
  output logic [imhq_pkg::KEY_W-1:0]  popped_key_o,
  output logic [imhq_pkg::STAT_W-1:0] status_o,
  output logic [imhq_pkg::CNT_W-1:0]  entry_count_o
);

  localparam int AW = (NODE_COUNT > 1) ? $clog2(NODE_COUNT) : 1;
  localparam int CW = $clog2(NODE_COUNT + 1);
  localparam int LW = AW + 2;
  localparam int IW = imhq_pkg::ID_W;
  localparam int KW = imhq_pkg::KEY_W;

  imhq_pkg::state_e state_q, state_d;
  logic [AW-1:0] init_cnt_q, init_cnt_d;
  logic [CW-1:0] size_q, size_d;
  logic [AW-1:0] pos_q, pos_d;
  logic [IW-1:0] item_id_q, item_id_d;
  logic [KW-1:0] item_key_q, item_key_d;
  imhq_pkg::req_e req_q, req_d;
  logic [IW-1:0] node_q, node_d;
  logic [KW-1:0] key_q, key_d;
  logic [IW-1:0] pop_id_q, pop_id_d;
  logic [KW-1:0] pop_key_q, pop_key_d;

  logic          done_q, done_d;
  logic          pvalid_q, pvalid_d;
  logic [IW-1:0] pnode_q, pnode_d;
  logic [KW-1:0] pkey_q, pkey_d;
  imhq_pkg::status_e status_q, status_d;

  // memory ports
  logic          h_we, h_re;
  logic [AW-1:0] h_waddr, h_raddr0, h_raddr1;
  logic [IW-1:0] h_wid, h_rid0, h_rid1;
  logic [KW-1:0] h_wkey, h_rkey0, h_rkey1;
  logic          s_we, s_re;
  logic [AW-1:0] s_waddr, s_raddr;
  logic [CW-1:0] s_wdata, s_rdata;

  imhq_heap_mem #(.NODE_COUNT(NODE_COUNT)) u_heap (
    .clk_i    (clk_i),
    .we_i     (h_we),
    .waddr_i  (h_waddr),
    .wid_i    (h_wid),
    .wkey_i   (h_wkey),
    .re_i     (h_re),
    .raddr0_i (h_raddr0),
    .raddr1_i (h_raddr1),
    .rid0_o   (h_rid0),
    .rkey0_o  (h_rkey0),
    .rid1_o   (h_rid1),
    .rkey1_o  (h_rkey1)
  );

  imhq_slot_mem #(.NODE_COUNT(NODE_COUNT)) u_slot (
    .clk_i   (clk_i),
    .we_i    (s_we),
    .waddr_i (s_waddr),
    .wdata_i (s_wdata),
    .re_i    (s_re),
    .raddr_i (s_raddr),
    .rdata_o (s_rdata)
  );

  // node id to memory index, and the range check of the requested id
  function automatic logic [AW-1:0] node_idx(input logic [IW-1:0] id);
    logic [31:0] ext;
    ext = 32'(id);
    return ext[AW-1:0];
  endfunction

  logic node_in_range;
  assign node_in_range = 32'(node_id_i) < 32'(NODE_COUNT);

  // derived values of the current slot
  logic [AW-1:0] parent_pos;
  logic [LW-1:0] left_pos, right_pos;
  logic [CW-1:0] pos_plus1;
  logic          slot_in_heap, id_match;
  logic          left_ok, right_ok, pick_left, pick_right;
  logic [KW-1:0] left_best_key;

  assign parent_pos   = (pos_q - AW'(1)) >> 1;
  assign left_pos     = (LW'(pos_q) << 1) + LW'(1);
  assign right_pos    = (LW'(pos_q) << 1) + LW'(2);
  assign pos_plus1    = CW'(pos_q) + CW'(1);
  assign slot_in_heap = (s_rdata != '0) && (s_rdata <= size_q);
  assign id_match     = (h_rid0 == node_q);
  assign left_ok      = left_pos < LW'(size_q);
  assign right_ok     = right_pos < LW'(size_q);
  assign pick_left    = left_ok && (h_rkey0 < item_key_q);
  assign left_best_key = pick_left ? h_rkey0 : item_key_q;
  assign pick_right   = right_ok && (h_rkey1 < left_best_key);

  // state and data registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= imhq_pkg::S_INIT;
      init_cnt_q <= '0;
      size_q     <= '0;
      done_q     <= 1'b0;
    end else begin
      state_q    <= state_d;
      init_cnt_q <= init_cnt_d;
      size_q     <= size_d;
      done_q     <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pos_q      <= pos_d;
    item_id_q  <= item_id_d;
    item_key_q <= item_key_d;
    req_q      <= req_d;
    node_q     <= node_d;
    key_q      <= key_d;
    pop_id_q   <= pop_id_d;
    pop_key_q  <= pop_key_d;
    pvalid_q   <= pvalid_d;
    pnode_q    <= pnode_d;
    pkey_q     <= pkey_d;
    status_q   <= status_d;
  end

  // sequencer: next state, memory accesses and result
  always_comb begin
    state_d    = state_q;
    init_cnt_d = init_cnt_q;
    size_d     = size_q;
    pos_d      = pos_q;
    item_id_d  = item_id_q;
    item_key_d = item_key_q;
    req_d      = req_q;
    node_d     = node_q;
    key_d      = key_q;
    pop_id_d   = pop_id_q;
    pop_key_d  = pop_key_q;
    done_d     = 1'b0;
    pvalid_d   = pvalid_q;
    pnode_d    = pnode_q;
    pkey_d     = pkey_q;
    status_d   = status_q;
    h_we       = 1'b0;
    h_waddr    = pos_q;
    h_wid      = item_id_q;
    h_wkey     = item_key_q;
    h_re       = 1'b0;
    h_raddr0   = '0;
    h_raddr1   = '0;
    s_we       = 1'b0;
    s_waddr    = node_idx(item_id_q);
    s_wdata    = pos_plus1;
    s_re       = 1'b0;
    s_raddr    = node_idx(node_id_i);

    case (state_q)
      // zero the slot-of-node memory after reset
      imhq_pkg::S_INIT: begin
        s_we       = 1'b1;
        s_waddr    = init_cnt_q;
        s_wdata    = '0;
        init_cnt_d = init_cnt_q + AW'(1);
        if (init_cnt_q == AW'(NODE_COUNT - 1)) begin
          state_d = imhq_pkg::S_IDLE;
        end
      end

      // take a transaction
      imhq_pkg::S_IDLE: begin
        if (start_i) begin
          req_d    = imhq_pkg::req_e'(req_type_i);
          node_d   = node_id_i;
          key_d    = new_key_i;
          pvalid_d = 1'b0;
          pnode_d  = '0;
          pkey_d   = '0;
          case (imhq_pkg::req_e'(req_type_i))
            imhq_pkg::REQ_PUSH, imhq_pkg::REQ_DEC: begin
              if (!node_in_range) begin
                done_d   = 1'b1;
                status_d = (imhq_pkg::req_e'(req_type_i) == imhq_pkg::REQ_PUSH) ?
                           imhq_pkg::ST_FULL : imhq_pkg::ST_ABSENT;
              end else begin
                s_re    = 1'b1;
                state_d = imhq_pkg::S_LOOKUP;
              end
            end
            imhq_pkg::REQ_POP: begin
              if (size_q == '0) begin
                done_d   = 1'b1;
                status_d = imhq_pkg::ST_EMPTY;
              end else begin
                h_re     = 1'b1;
                h_raddr0 = '0;
                h_raddr1 = AW'(size_q - CW'(1));
                state_d  = imhq_pkg::S_POP_LD;
              end
            end
            default: begin
              size_d   = '0;
              done_d   = 1'b1;
              status_d = imhq_pkg::ST_OK;
            end
          endcase
        end
      end

      // slot entry is read; a stale entry is caught by checking the heap id
      imhq_pkg::S_LOOKUP, imhq_pkg::S_VERIFY: begin
        logic present;
        present = 1'b0;
        if (state_q == imhq_pkg::S_LOOKUP) begin
          if (slot_in_heap) begin
            h_re     = 1'b1;
            h_raddr0 = AW'(s_rdata - CW'(1));
            pos_d    = AW'(s_rdata - CW'(1));
            state_d  = imhq_pkg::S_VERIFY;
          end
        end else begin
          present = id_match;
        end
        if (state_q == imhq_pkg::S_VERIFY || !slot_in_heap) begin
          item_id_d  = node_q;
          item_key_d = key_q;
          if (req_q == imhq_pkg::REQ_PUSH) begin
            if (present) begin
              done_d   = 1'b1;
              status_d = imhq_pkg::ST_PRESENT;
              state_d  = imhq_pkg::S_IDLE;
            end else if (size_q >= CW'(NODE_COUNT)) begin
              done_d   = 1'b1;
              status_d = imhq_pkg::ST_FULL;
              state_d  = imhq_pkg::S_IDLE;
            end else begin
              pos_d   = AW'(size_q);
              size_d  = size_q + CW'(1);
              state_d = imhq_pkg::S_UP_ISSUE;
            end
          end else begin
            if (present) begin
              state_d = imhq_pkg::S_UP_ISSUE;
            end else begin
              done_d   = 1'b1;
              status_d = imhq_pkg::ST_ABSENT;
              state_d  = imhq_pkg::S_IDLE;
            end
          end
        end
      end

      // sift up: read the parent, or settle at the root
      imhq_pkg::S_UP_ISSUE: begin
        if (pos_q == '0) begin
          h_we     = 1'b1;
          s_we     = 1'b1;
          done_d   = 1'b1;
          status_d = imhq_pkg::ST_OK;
          state_d  = imhq_pkg::S_IDLE;
        end else begin
          h_re     = 1'b1;
          h_raddr0 = parent_pos;
          state_d  = imhq_pkg::S_UP_CMP;
        end
      end

      // sift up: move the parent down on a strictly smaller key
      imhq_pkg::S_UP_CMP: begin
        h_we = 1'b1;
        s_we = 1'b1;
        if (item_key_q < h_rkey0) begin
          h_wid   = h_rid0;
          h_wkey  = h_rkey0;
          s_waddr = node_idx(h_rid0);
          pos_d   = parent_pos;
          state_d = imhq_pkg::S_UP_ISSUE;
        end else begin
          done_d   = 1'b1;
          status_d = imhq_pkg::ST_OK;
          state_d  = imhq_pkg::S_IDLE;
        end
      end

      // pop: root and last slot are read; last entry moves to the root
      imhq_pkg::S_POP_LD: begin
        pop_id_d   = h_rid0;
        pop_key_d  = h_rkey0;
        item_id_d  = h_rid1;
        item_key_d = h_rkey1;
        size_d     = size_q - CW'(1);
        pos_d      = '0;
        if (size_q == CW'(1)) begin
          done_d   = 1'b1;
          status_d = imhq_pkg::ST_OK;
          pvalid_d = 1'b1;
          pnode_d  = h_rid0;
          pkey_d   = h_rkey0;
          state_d  = imhq_pkg::S_IDLE;
        end else begin
          state_d = imhq_pkg::S_DN_ISSUE;
        end
      end

      // sift down: read both children
      imhq_pkg::S_DN_ISSUE: begin
        h_re     = 1'b1;
        h_raddr0 = left_pos[AW-1:0];
        h_raddr1 = right_pos[AW-1:0];
        state_d  = imhq_pkg::S_DN_CMP;
      end

      // sift down: move the smaller child up, left wins a tie
      imhq_pkg::S_DN_CMP: begin
        h_we = 1'b1;
        s_we = 1'b1;
        if (pick_right) begin
          h_wid   = h_rid1;
          h_wkey  = h_rkey1;
          s_waddr = node_idx(h_rid1);
          pos_d   = right_pos[AW-1:0];
          state_d = imhq_pkg::S_DN_ISSUE;
        end else if (pick_left) begin
          h_wid   = h_rid0;
          h_wkey  = h_rkey0;
          s_waddr = node_idx(h_rid0);
          pos_d   = left_pos[AW-1:0];
          state_d = imhq_pkg::S_DN_ISSUE;
        end else begin
          done_d   = 1'b1;
          status_d = imhq_pkg::ST_OK;
          pvalid_d = 1'b1;
          pnode_d  = pop_id_q;
          pkey_d   = pop_key_q;
          state_d  = imhq_pkg::S_IDLE;
        end
      end

      default: begin
        state_d = imhq_pkg::S_IDLE;
      end
    endcase
  end

  // outputs
  assign busy_o        = (state_q != imhq_pkg::S_IDLE);
  assign done_o        = done_q;
  assign pop_valid_o   = pvalid_q;
  assign popped_node_o = pnode_q;
  assign popped_key_o  = pkey_q;
  assign status_o      = status_q;
  assign entry_count_o = imhq_pkg::CNT_W'(size_q);

endmodule

FILE: src/imhq_checker.sv
// port-level checker for the indexed min-heap queue, bound to the top level
// depends on imhq_pkg and indexed_min_heap_queue
module imhq_checker (
  input logic                        clk_i,
  input logic                        rst_ni,
  input logic                        start_i,
  input logic [imhq_pkg::REQ_W-1:0]  req_type_i,
  input logic [imhq_pkg::ID_W-1:0]   node_id_i,
  input logic [imhq_pkg::KEY_W-1:0]  new_key_i,
  input logic                        busy_o,
  input logic                        done_o,
  input logic                        pop_valid_o,
  input logic [imhq_pkg::ID_W-1:0]   popped_node_o,
  input logic [imhq_pkg::KEY_W-1:0]  popped_key_o,
  input logic [imhq_pkg::STAT_W-1:0] status_o,
  input logic [imhq_pkg::CNT_W-1:0]  entry_count_o
);

  // a result strobe leaves the block ready for the next transaction
  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !busy_o)
    else $error("result strobe while busy");

  // an accepted transaction either finishes at once or holds busy
  a_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o) |=> (done_o || busy_o))
    else $error("transaction lost");

  // a returned node always comes with ok status
  a_pop_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && pop_valid_o) |-> (status_o == imhq_pkg::ST_OK))
    else $error("popped node with error status");

  // empty answer only on an empty heap
  a_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && status_o == imhq_pkg::ST_EMPTY) |-> (entry_count_o == '0))
    else $error("empty status with entries");

  // no pop payload without a pop
  a_no_payload: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && !pop_valid_o) |-> (popped_node_o == '0 && popped_key_o == '0))
    else $error("pop payload without pop");

endmodule

bind indexed_min_heap_queue imhq_checker u_imhq_checker (.*);

FILE: verif/indexed_min_heap_queue_test.sv
// self-checking testbench for the indexed min-heap queue
// holds its own heap predictor, a queued command driver and a result monitor
// depends on imhq_pkg and indexed_min_heap_queue
`timescale 1ns / 1ps

module indexed_min_heap_queue_test;

  localparam int HEAP_DEPTH = imhq_pkg::NODE_COUNT_DEF;
  localparam int ID_W       = imhq_pkg::ID_W;
  localparam int KEY_W      = imhq_pkg::KEY_W;
  localparam int REQ_W      = imhq_pkg::REQ_W;
  localparam int STAT_W     = imhq_pkg::STAT_W;
  localparam int CNT_W      = imhq_pkg::CNT_W;

  typedef struct {
    imhq_pkg::req_e    op;
    logic [ID_W-1:0]   node;
    logic [KEY_W-1:0]  key;
    int unsigned       gap_pct;
    bit                drain;
  } heap_cmd_t;

  typedef struct {
    logic              pop_valid;
    logic [ID_W-1:0]   node;
    logic [KEY_W-1:0]  key;
    imhq_pkg::status_e status;
    logic [CNT_W-1:0]  count;
  } heap_resp_t;

  logic              clk_i = 1'b0;
  logic              rst_ni = 1'b0;
  logic              start_i = 1'b0;
  logic [REQ_W-1:0]  req_type_i = '0;
  logic [ID_W-1:0]   node_id_i = '0;
  logic [KEY_W-1:0]  new_key_i = '0;
  logic              busy_o, done_o, pop_valid_o;
  logic [ID_W-1:0]   popped_node_o;
  logic [KEY_W-1:0]  popped_key_o;
  logic [STAT_W-1:0] status_o;
  logic [CNT_W-1:0]  entry_count_o;

  heap_cmd_t  cmd_queue[$];
  heap_resp_t resp_queue[$];
  int unsigned mismatch_count = 0;

  // predictor state
  logic [ID_W-1:0]  pred_ids[HEAP_DEPTH];
  logic [KEY_W-1:0] pred_keys[HEAP_DEPTH];
  logic [CNT_W-1:0] pred_slot[HEAP_DEPTH];
  int unsigned      pred_size = 0;

  indexed_min_heap_queue dut (
    .clk_i, .rst_ni, .start_i, .req_type_i, .node_id_i, .new_key_i,
    .busy_o, .done_o, .pop_valid_o, .popped_node_o, .popped_key_o,
    .status_o, .entry_count_o
  );

  always #4 clk_i = ~clk_i;

  // predictor helpers
  task automatic swap_entries(input int unsigned a, input int unsigned b);
    logic [ID_W-1:0]  tid;
    logic [KEY_W-1:0] tkey;
    tid = pred_ids[a];
    tkey = pred_keys[a];
    pred_ids[a] = pred_ids[b];
    pred_keys[a] = pred_keys[b];
    pred_ids[b] = tid;
    pred_keys[b] = tkey;
    pred_slot[pred_ids[a]] = CNT_W'(a + 1);
    pred_slot[pred_ids[b]] = CNT_W'(b + 1);
  endtask

  task automatic bubble_up(input int unsigned pos);
    int unsigned parent;
    while (pos > 0) begin
      parent = (pos - 1) / 2;
      if (pred_keys[pos] < pred_keys[parent]) begin
        swap_entries(pos, parent);
        pos = parent;
      end else begin
        break;
      end
    end
  endtask

  task automatic bubble_down(input int unsigned pos);
    int unsigned lc, rc, best;
    while (pos < pred_size) begin
      lc = pos * 2 + 1;
      rc = pos * 2 + 2;
      best = pos;
      if (lc < pred_size && pred_keys[lc] < pred_keys[best]) best = lc;
      if (rc < pred_size && pred_keys[rc] < pred_keys[best]) best = rc;
      if (best == pos) break;
      swap_entries(pos, best);
      pos = best;
    end
  endtask

  // apply one command to the predicted heap and queue its expected response
  task automatic predict_heap_op(input heap_cmd_t c);
    heap_resp_t  r;
    int unsigned last, s;
    r.pop_valid = 1'b0;
    r.node = '0;
    r.key = '0;
    r.status = imhq_pkg::ST_OK;
    case (c.op)
      imhq_pkg::REQ_PUSH: begin
        if (pred_slot[c.node] != '0) begin
          r.status = imhq_pkg::ST_PRESENT;
        end else if (pred_size >= HEAP_DEPTH) begin
          r.status = imhq_pkg::ST_FULL;
        end else begin
          pred_ids[pred_size] = c.node;
          pred_keys[pred_size] = c.key;
          pred_slot[c.node] = CNT_W'(pred_size + 1);
          pred_size++;
          bubble_up(pred_size - 1);
        end
      end
      imhq_pkg::REQ_POP: begin
        if (pred_size == 0) begin
          r.status = imhq_pkg::ST_EMPTY;
        end else begin
          last = pred_size - 1;
          r.pop_valid = 1'b1;
          r.node = pred_ids[0];
          r.key = pred_keys[0];
          pred_ids[0] = pred_ids[last];
          pred_keys[0] = pred_keys[last];
          pred_slot[pred_ids[0]] = CNT_W'(1);
          pred_size = last;
          bubble_down(0);
          pred_slot[r.node] = '0;
        end
      end
      imhq_pkg::REQ_DEC: begin
        s = pred_slot[c.node];
        if (s == 0 || s > pred_size) begin
          r.status = imhq_pkg::ST_ABSENT;
        end else begin
          pred_keys[s - 1] = c.key;
          bubble_up(s - 1);
        end
      end
      default: begin
        foreach (pred_slot[i]) pred_slot[i] = '0;
        pred_size = 0;
      end
    endcase
    r.count = CNT_W'(pred_size);
    resp_queue.push_back(r);
  endtask

  task automatic report_mismatch(input string field, input logic [63:0] got,
                                 input logic [63:0] want);
    mismatch_count++;
    $display("%0t: mismatch on %s: got %0h, expected %0h", $realtime, field, got, want);
  endtask

  // driver: holds start until the transaction is taken
  always @(posedge clk_i or negedge rst_ni) begin
    bit        taken, nxt_start;
    heap_cmd_t c;
    if (!rst_ni) begin
      start_i <= 1'b0;
    end else begin
      taken = start_i && !busy_o;
      nxt_start = start_i && !taken;
      if (taken) begin
        predict_heap_op(cmd_queue.pop_front());
      end
      if (!nxt_start && cmd_queue.size() > 0) begin
        c = cmd_queue[0];
        if (!(c.drain && (resp_queue.size() > 0 || busy_o)) &&
            $urandom_range(99) >= c.gap_pct) begin
          nxt_start = 1'b1;
          req_type_i <= c.op;
          node_id_i <= c.node;
          new_key_i <= c.key;
        end
      end
      start_i <= nxt_start;
    end
  end

  // monitor: every result strobe is checked against the oldest expectation
  always @(posedge clk_i) begin
    heap_resp_t w;
    if (rst_ni && done_o) begin
      if (resp_queue.size() == 0) begin
        report_mismatch("unexpected transaction", 1, 0);
      end else begin
        w = resp_queue.pop_front();
        if (pop_valid_o !== w.pop_valid) report_mismatch("pop_valid", pop_valid_o, w.pop_valid);
        if (popped_node_o !== w.node) report_mismatch("popped_node", popped_node_o, w.node);
        if (popped_key_o !== w.key) report_mismatch("popped_key", popped_key_o, w.key);
        if (status_o !== w.status) report_mismatch("status", status_o, w.status);
        if (entry_count_o !== w.count) report_mismatch("entry_count", entry_count_o, w.count);
      end
    end
  end

  function automatic logic [KEY_W-1:0] pick_key();
    case ($urandom_range(5))
      0: return $urandom();
      1: return $urandom_range(15);
      2: return $urandom_range(2000);
      3: return $urandom_range(1) ? '1 : '0;
      default: return $urandom_range(200000);
    endcase
  endfunction

  function automatic logic [ID_W-1:0] pick_node();
    return ($urandom_range(9) == 0) ? ID_W'($urandom()) : ID_W'($urandom_range(47));
  endfunction

  task automatic add_cmd(input imhq_pkg::req_e op, input logic [ID_W-1:0] node,
                         input logic [KEY_W-1:0] key, input int unsigned pct,
                         input bit drain = 1'b0);
    heap_cmd_t c;
    c.op = op;
    c.node = node;
    c.key = key;
    c.gap_pct = pct;
    c.drain = drain;
    cmd_queue.push_back(c);
  endtask

  // stimulus and end of run
  initial begin
    int unsigned pcts[4] = '{0, 74, 0, 19};
    int unsigned sel;
    foreach (pred_slot[i]) pred_slot[i] = '0;
    // directed: extremes, ties, the empty, present and absent cases, raised key, clear
    add_cmd(imhq_pkg::REQ_POP, 0, 0, 0);
    add_cmd(imhq_pkg::REQ_PUSH, 0, 32'h0, 0);
    add_cmd(imhq_pkg::REQ_PUSH, 12'hfff, 32'hffff_ffff, 0);
    add_cmd(imhq_pkg::REQ_PUSH, 5, 100, 0);
    add_cmd(imhq_pkg::REQ_PUSH, 6, 100, 0);
    add_cmd(imhq_pkg::REQ_PUSH, 7, 100, 0);
    add_cmd(imhq_pkg::REQ_PUSH, 12'haaa, 32'haaaa_5555, 0);
    add_cmd(imhq_pkg::REQ_PUSH, 12'h555, 32'h5555_aaaa, 0);
    add_cmd(imhq_pkg::REQ_PUSH, 5, 1, 0);
    add_cmd(imhq_pkg::REQ_DEC, 12'hfff, 50, 0);
    add_cmd(imhq_pkg::REQ_DEC, 6, 200, 0);
    add_cmd(imhq_pkg::REQ_DEC, 9, 3, 0);
    add_cmd(imhq_pkg::REQ_DEC, 7, 0, 0);
    for (int i = 0; i < 8; i++) add_cmd(imhq_pkg::REQ_POP, 0, 0, 0);
    add_cmd(imhq_pkg::REQ_PUSH, 1, 10, 0);
    add_cmd(imhq_pkg::REQ_PUSH, 2, 5, 0);
    add_cmd(imhq_pkg::REQ_CLEAR, 0, 0, 0);
    add_cmd(imhq_pkg::REQ_DEC, 1, 1, 0);
    // random phases, two without sender gaps and two with; each phase opens after a drain
    foreach (pcts[p]) begin
      for (int i = 0; i < 200; i++) begin
        sel = $urandom_range(99);
        if (sel < 45) begin
          add_cmd(imhq_pkg::REQ_PUSH, pick_node(), pick_key(), pcts[p], i == 0);
        end else if (sel < 75) begin
          add_cmd(imhq_pkg::REQ_POP, ID_W'($urandom()), $urandom(), pcts[p], i == 0);
        end else if (sel < 97) begin
          add_cmd(imhq_pkg::REQ_DEC, pick_node(), pick_key(), pcts[p], i == 0);
        end else begin
          add_cmd(imhq_pkg::REQ_CLEAR, ID_W'($urandom()), $urandom(), pcts[p], i == 0);
        end
      end
    end
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    do @(posedge clk_i); while (cmd_queue.size() > 0 || resp_queue.size() > 0);
    repeat (60) @(posedge clk_i);
    if (mismatch_count == 0 && resp_queue.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  // watchdog
  initial begin
    #20ms;
    $display("simulation failed");
    $finish;
  end

endmodule
